// ===== rtl/core/obr_pkg.sv =====
`default_nettype none

package obr_pkg;

    localparam int DEF_SHOWN_BANDS = 6;
    localparam int DEF_BAR_HEIGHT  = 24;
    localparam int DEF_LEVEL_CLAMP = 128;

    localparam int BIN_W     = 9;
    localparam int BAND_W    = 3;
    localparam int SUM_W     = 22;
    localparam int SCALED_W  = 21;   // covers LEVEL_CLAMP * BAR_HEIGHT at their maxima
    localparam int PIX_IDX_W = 8;
    localparam int COLOR_W   = 32;
    localparam int TIERS     = 3;

    localparam logic [COLOR_W-1:0] LOW_TIER_RESET  = 32'h0000_FF00;
    localparam logic [COLOR_W-1:0] MID_TIER_RESET  = 32'h00FF_0000;
    localparam logic [COLOR_W-1:0] HIGH_TIER_RESET = 32'hFF00_0000;

    localparam logic [BIN_W-1:0] BIN_MAX = 9'd511;

    typedef enum logic [1:0] {
        CFG_LOW_TIER  = 2'd0,
        CFG_MID_TIER  = 2'd1,
        CFG_HIGH_TIER = 2'd2
    } cfg_reg_t;

    typedef logic [TIERS-1:0][COLOR_W-1:0] tier_colors_t;

    typedef struct packed {
        logic signed [15:0] bin_value;
        logic               frame_start;
    } bin_in_t;

    typedef struct packed {
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 run_last;
        logic                 frame_done;
    } pixel_out_t;

    // One finished band handed to the pixel emitter.
    typedef struct packed {
        logic [BAND_W-1:0]   band;
        logic [SCALED_W-1:0] scaled;   // clamped mean times BAR_HEIGHT
    } burst_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/octave_band_led_bar_renderer.sv =====
`default_nettype none

// Octave-band LED bar renderer.
// bin channel (bin_valid/bin_ready/bin_data): FFT bins in ascending order, one
// transaction per bin; frame_start marks bin 0 of a frame. Band k sums bins
// 2^k+1 .. 2^(k+1); its mean is clamped, scaled to a bar height and drawn.
// pix channel (pix_valid/pix_ready/pix_data): BAR_HEIGHT pixels per finished
// shown band, level 0 first, run_last on the top level, frame_done on the top
// level of the last shown band.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): tier colors, always
// ready; write only while the block is idle.
// Throughput: one bin per cycle while the pending slot is free. A finished
// band is drawn at one pixel per cycle by the emitter while pix_ready is high;
// one finished band can wait in the emitter's pending slot while another is
// drawn, and bin_ready drops only while that slot is full.
// When the emitter is free, a band's last bin is registered in the pending
// slot, then moved to the active slot, which drives the band's first pixel.
// Reset clears the counters, the band sum, both emitter slots and restores
// the default tier colors. When the pix receiver stalls, the current pixel
// holds and bins keep flowing until the pending slot fills.

module octave_band_led_bar_renderer
    import obr_pkg::*;
#(
    parameter int SHOWN_BANDS = DEF_SHOWN_BANDS,
    parameter int BAR_HEIGHT  = DEF_BAR_HEIGHT,
    parameter int LEVEL_CLAMP = DEF_LEVEL_CLAMP
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         bin_valid,
    output logic              bin_ready,
    input  wire bin_in_t      bin_data,
    output logic              pix_valid,
    input  wire logic         pix_ready,
    output pixel_out_t        pix_data,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [COLOR_W-1:0] cfg_data
);

    localparam int CLAMP_W = $clog2(LEVEL_CLAMP + 1);

    logic [BIN_W-1:0]        bin_counter_reg, bin_counter_next;
    logic [BAND_W-1:0]       band_reg, band_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    done_reg, done_next;
    tier_colors_t            colors_reg;

    logic                    accept;
    logic [BIN_W-1:0]        bin;
    logic [BAND_W-1:0]       band;
    logic signed [SUM_W-1:0] sum;
    logic                    done;
    logic                    in_range;
    logic                    complete;
    logic signed [SUM_W-1:0] sum_new;
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] mean;
    logic [CLAMP_W-1:0]      mean_clamped;
    burst_req_t              req;
    logic                    req_valid;
    logic                    req_ready;

    assign accept = bin_valid && bin_ready;

    always_comb
    begin
        // frame start clears the state before the bin is taken
        bin  = bin_data.frame_start ? '0 : bin_counter_reg;
        band = bin_data.frame_start ? '0 : band_reg;
        sum  = bin_data.frame_start ? '0 : sum_reg;
        done = bin_data.frame_start ? 1'b0 : done_reg;

        in_range = (bin >= BIN_W'(2)) && !done
                   && ({1'b0, band} < (BAND_W + 1)'(SHOWN_BANDS));
        sum_new  = sum + {{(SUM_W - 16){bin_data.bin_value[15]}}, bin_data.bin_value};
        complete = in_range && (bin == (BIN_W'(2) << band));

        // divide by 2^band, truncating toward zero
        bias   = (SUM_W'(1) << band) - SUM_W'(1);
        biased = sum_new[SUM_W-1] ? (sum_new + bias) : sum_new;
        mean   = biased >>> band;

        if (mean > $signed(SUM_W'(LEVEL_CLAMP)))
        begin
            mean_clamped = CLAMP_W'(LEVEL_CLAMP);
        end
        else
        begin
            mean_clamped = mean[CLAMP_W-1:0];
        end

        req.band = band;
        if (mean[SUM_W-1] || (mean == '0))
        begin
            req.scaled = '0;
        end
        else
        begin
            req.scaled = SCALED_W'(32'(mean_clamped) * 32'(BAR_HEIGHT));
        end
        req_valid = accept && complete;

        bin_counter_next = (bin < BIN_MAX) ? (bin + BIN_W'(1)) : bin;
        band_next        = band;
        sum_next         = sum;
        done_next        = done;
        if (in_range)
        begin
            sum_next = sum_new;
            if (complete)
            begin
                sum_next = '0;
                if ((32'(band) + 32'd1) >= 32'(SHOWN_BANDS))
                begin
                    done_next = 1'b1;
                    band_next = '0;
                end
                else
                begin
                    band_next = band + BAND_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_counter_reg <= '0;
            band_reg        <= '0;
            sum_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else if (accept)
        begin
            bin_counter_reg <= bin_counter_next;
            band_reg        <= band_next;
            sum_reg         <= sum_next;
            done_reg        <= done_next;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg[0] <= LOW_TIER_RESET;
            colors_reg[1] <= MID_TIER_RESET;
            colors_reg[2] <= HIGH_TIER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOW_TIER:  colors_reg[0] <= cfg_data;
                CFG_MID_TIER:  colors_reg[1] <= cfg_data;
                CFG_HIGH_TIER: colors_reg[2] <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign bin_ready = req_ready;

    obr_pixel_emitter #(
        .SHOWN_BANDS (SHOWN_BANDS),
        .BAR_HEIGHT  (BAR_HEIGHT),
        .LEVEL_CLAMP (LEVEL_CLAMP)
    ) u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .tier_colors (colors_reg),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix_data    (pix_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/obr_pixel_emitter.sv =====
`default_nettype none

module obr_pixel_emitter
    import obr_pkg::*;
#(
    parameter int SHOWN_BANDS = DEF_SHOWN_BANDS,
    parameter int BAR_HEIGHT  = DEF_BAR_HEIGHT,
    parameter int LEVEL_CLAMP = DEF_LEVEL_CLAMP
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire burst_req_t   req,
    input  wire tier_colors_t tier_colors,
    output logic              pix_valid,
    input  wire logic         pix_ready,
    output pixel_out_t        pix_data
);

    localparam int LVL_W = (BAR_HEIGHT > 1) ? $clog2(BAR_HEIGHT) : 1;
    localparam int THR_W = $clog2(BAR_HEIGHT * LEVEL_CLAMP + 1);
    localparam logic [LVL_W-1:0]  LAST_LEVEL = LVL_W'(BAR_HEIGHT - 1);
    localparam logic [BAND_W-1:0] LAST_BAND  = BAND_W'(SHOWN_BANDS - 1);

    logic             pend_valid_reg, pend_valid_next;
    burst_req_t       pend_reg;
    logic             act_valid_reg, act_valid_next;
    burst_req_t       act_reg;
    logic [LVL_W-1:0] level_reg, level_next;

    logic             fire;
    logic             last;
    logic             load;
    logic [THR_W-1:0] thr;
    logic [31:0]      level3;
    logic [1:0]       tier;
    logic             lit;

    assign req_ready = !pend_valid_reg;
    assign fire      = act_valid_reg && pix_ready;
    assign last      = (level_reg == LAST_LEVEL);
    // next burst starts right behind the last pixel of the current one
    assign load      = pend_valid_reg && (!act_valid_reg || (fire && last));

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (req_valid && req_ready)
        begin
            pend_valid_next = 1'b1;
        end
        else if (load)
        begin
            pend_valid_next = 1'b0;
        end

        act_valid_next = act_valid_reg;
        level_next     = level_reg;
        if (load)
        begin
            act_valid_next = 1'b1;
            level_next     = '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                act_valid_next = 1'b0;
            end
            level_next = level_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            level_reg      <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg  <= act_valid_next;
            level_reg      <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            pend_reg <= req;
        end
        if (load)
        begin
            act_reg <= pend_reg;
        end
    end

    // level lit when height > level, i.e. scaled >= (level+1) * LEVEL_CLAMP
    always_comb
    begin
        thr    = THR_W'((32'(level_reg) + 32'd1) * 32'(LEVEL_CLAMP));
        lit    = (act_reg.scaled >= SCALED_W'(thr));
        level3 = 32'(level_reg) * 32'd3;
        if (level3 >= 32'(2 * BAR_HEIGHT))
        begin
            tier = 2'd2;
        end
        else if (level3 >= 32'(BAR_HEIGHT))
        begin
            tier = 2'd1;
        end
        else
        begin
            tier = 2'd0;
        end
    end

    assign pix_valid            = act_valid_reg;
    assign pix_data.pixel_index = PIX_IDX_W'(32'(act_reg.band) * 32'(BAR_HEIGHT)
                                             + 32'(level_reg));
    assign pix_data.pixel_color = lit ? tier_colors[tier] : '0;
    assign pix_data.run_last    = last;
    assign pix_data.frame_done  = last && (act_reg.band == LAST_BAND);

endmodule

`default_nettype wire

// ===== rtl/core/obr_checker.sv =====
`default_nettype none

module obr_checker
    import obr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pix_valid,
    input wire logic       pix_ready,
    input wire pixel_out_t pix_data
);

    // a stalled pixel stays offered
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid)
        else $error("pixel withdrawn while stalled");

    a_pix_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> $stable(pix_data))
        else $error("pixel changed while stalled");

    // within a run the strip index steps by one with no gap
    a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && !pix_data.run_last |=>
            pix_valid
            && (pix_data.pixel_index == $past(pix_data.pixel_index) + PIX_IDX_W'(1)))
        else $error("pixel run broken");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_data.frame_done |-> pix_data.run_last)
        else $error("frame_done outside run end");

endmodule

bind octave_band_led_bar_renderer obr_checker u_obr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data)
);

`default_nettype wire
